FILE: src/gbr_pkg.sv
// Package for the Gaussian blur core: sizes, commands, register indexes and states.
// No dependencies; imported by the core and the checker.
package gbr_pkg;

  localparam int MAX_WIDTH    = 2048;
  localparam int MAX_RADIUS   = 3;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int SIDE_LIMIT   = 2 * MAX_RADIUS + 1;
  localparam int WEIGHT_DEPTH = SIDE_LIMIT * SIDE_LIMIT;
  localparam int STORE_DEPTH  = MAX_WIDTH * SIDE_LIMIT;
  localparam int STORE_AW     = $clog2(STORE_DEPTH);
  localparam int WEIGHT_AW    = $clog2(WEIGHT_DEPTH);

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_PIXEL = 2'd1,
    CMD_DRAIN = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_RADIUS = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BACK,
    S_TAP,
    S_DRAIN,
    S_DONE
  } state_t;

endpackage

FILE: src/gbr_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module gbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/gaussian_blur_rgb_clamp_edges_core.sv
// Gaussian blur core, top level. A command item that loads a weight, stores a pixel
// that releases nothing, or is ignored leaves the core in S_IDLE. An item that releases
// a result walks S_BACK, S_TAP, S_DRAIN, S_DONE: one tap per cycle is read from the pixel
// ring RAM and the weight RAM, then multiplied and accumulated for all three channels.
// Pixels live in a 14336-entry ring (seven rows of the widest image); weights in a
// 49-entry RAM whose entries read as zero until loaded. Depends on gbr_pkg and gbr_ram.
module gaussian_blur_rgb_clamp_edges_core
  import gbr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [1:0]   command,
  input  logic [5:0]   coef_index,
  input  logic signed [17:0] coef_value,
  input  logic [7:0]   in_blue,
  input  logic [7:0]   in_green,
  input  logic [7:0]   in_red,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [7:0]   out_blue,
  output logic [7:0]   out_green,
  output logic [7:0]   out_red,
  output logic         frame_end,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [12:0]  cfg_data
);

  // configuration and effective geometry
  logic [11:0] image_width;
  logic [12:0] image_height;
  logic [1:0]  kernel_radius;
  logic [11:0] eff_w;
  logic [12:0] eff_h;
  logic [23:0] total;
  logic [2:0]  side;
  logic [13:0] thr;
  logic [24:0] total_full;
  logic [13:0] thr_full;

  always_comb begin
    eff_w = (image_width == 12'd0) ? 12'd1 :
            (image_width > 12'(MAX_WIDTH)) ? 12'(MAX_WIDTH) : image_width;
    eff_h = (image_height == 13'd0) ? 13'd1 :
            (image_height > 13'(HEIGHT_LIMIT)) ? 13'(HEIGHT_LIMIT) : image_height;
    total_full = eff_w * eff_h;
    total = total_full[23:0];
    side = {kernel_radius, 1'b1};
    thr_full = 14'(kernel_radius) * 14'(eff_w) + 14'(kernel_radius);
    thr = thr_full;
  end

  function automatic logic [STORE_AW-1:0] add_mod(logic [STORE_AW-1:0] a, logic [11:0] b);
    logic [STORE_AW:0] s;
    s = {1'b0, a} + (STORE_AW+1)'(b);
    if (s >= (STORE_AW+1)'(STORE_DEPTH)) s = s - (STORE_AW+1)'(STORE_DEPTH);
    return s[STORE_AW-1:0];
  endfunction

  function automatic logic [STORE_AW-1:0] sub_mod(logic [STORE_AW-1:0] a, logic [11:0] b);
    logic [STORE_AW:0] s;
    if (a >= STORE_AW'(b)) s = {1'b0, a} - (STORE_AW+1)'(b);
    else s = {1'b0, a} + (STORE_AW+1)'(STORE_DEPTH) - (STORE_AW+1)'(b);
    return s[STORE_AW-1:0];
  endfunction

  function automatic logic [7:0] finish(logic signed [33:0] acc);
    logic [17:0] q;
    q = acc[33:16];
    if (acc < 0) return 8'd0;
    if (q > 18'd255) return 8'd255;
    return q[7:0];
  endfunction

  // control and frame registers
  state_t state, state_next;
  logic [23:0] input_count;
  logic [23:0] output_count;
  logic [10:0] out_x;
  logic [11:0] out_y;
  logic [STORE_AW-1:0] out_base;
  logic [STORE_AW-1:0] in_addr;
  logic [STORE_AW-1:0] cur_base;
  logic [11:0] cur_py;
  logic [1:0]  back_cnt;
  logic [2:0]  kx, ky;
  logic [WEIGHT_AW-1:0] widx;
  logic [WEIGHT_DEPTH-1:0] wvalid;
  logic wv_q, v1, v2;
  logic signed [26:0] prod [3];
  logic signed [33:0] acc [3];

  logic in_acc, cfg_acc, out_load;
  logic is_pixel, pix_take, start_emit;
  logic [23:0] in_count_inc;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign cfg_acc   = cfg_valid && (cfg_index != REG_NONE);
  assign is_pixel  = (command == CMD_PIXEL);
  assign pix_take  = in_acc && is_pixel && (input_count < total);
  assign in_count_inc = input_count + 24'd1;
  assign start_emit = in_acc && ((pix_take && (in_count_inc > 24'(thr))) ||
                      ((command == CMD_DRAIN) && (input_count >= total) &&
                       (output_count < total)));
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  // tap address generation
  logic signed [13:0] xx;
  logic signed [14:0] yy;
  logic [10:0] px;
  logic [11:0] next_py;
  logic [STORE_AW:0] addr_sum;
  logic [STORE_AW-1:0] store_raddr;
  logic tap_last_col, tap_last;

  always_comb begin
    xx = $signed({3'b0, out_x}) - $signed({12'b0, kernel_radius}) + $signed({11'b0, kx});
    if (xx < 0) px = 11'd0;
    else if (xx > $signed({2'b0, eff_w} - 14'sd1)) px = 11'(eff_w - 12'd1);
    else px = xx[10:0];
    yy = $signed({3'b0, out_y}) - $signed({13'b0, kernel_radius}) +
         $signed({12'b0, ky}) + 15'sd1;
    if (yy < 0) next_py = 12'd0;
    else if (yy > $signed({2'b0, eff_h} - 15'sd1)) next_py = 12'(eff_h - 13'd1);
    else next_py = yy[11:0];
    addr_sum = {1'b0, cur_base} + (STORE_AW+1)'(px);
    if (addr_sum >= (STORE_AW+1)'(STORE_DEPTH))
      addr_sum = addr_sum - (STORE_AW+1)'(STORE_DEPTH);
    store_raddr = addr_sum[STORE_AW-1:0];
    tap_last_col = (kx == side - 3'd1);
    tap_last = tap_last_col && (ky == side - 3'd1);
  end

  // memories
  logic [23:0] store_rdata;
  logic [17:0] w_rdata;
  logic w_we;

  assign w_we = in_acc && (command == CMD_LOAD) && (coef_index < 6'(WEIGHT_DEPTH));

  gbr_ram #(.WIDTH(24), .DEPTH(STORE_DEPTH)) u_store (
    .clk  (clk),
    .we   (pix_take),
    .waddr(in_addr),
    .wdata({in_red, in_green, in_blue}),
    .raddr(store_raddr),
    .rdata(store_rdata)
  );

  gbr_ram #(.WIDTH(18), .DEPTH(WEIGHT_DEPTH)) u_weight (
    .clk  (clk),
    .we   (w_we),
    .waddr(coef_index[WEIGHT_AW-1:0]),
    .wdata(coef_value),
    .raddr(widx),
    .rdata(w_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (start_emit) state_next = S_BACK;
      S_BACK:  if (back_cnt == 2'd0) state_next = S_TAP;
      S_TAP:   if (tap_last) state_next = S_DRAIN;
      S_DRAIN: if (!v1 && !v2) state_next = S_DONE;
      S_DONE:  if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // configuration, counters and window walk
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= 12'(MAX_WIDTH);
      image_height  <= 13'd1;
      kernel_radius <= 2'd1;
      input_count   <= '0;
      output_count  <= '0;
      out_x         <= '0;
      out_y         <= '0;
      out_base      <= '0;
      in_addr       <= '0;
      wvalid        <= '0;
      v1            <= 1'b0;
      v2            <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_acc) begin
        unique case (cfg_index)
          REG_WIDTH:  image_width   <= cfg_data[11:0];
          REG_HEIGHT: image_height  <= cfg_data;
          REG_RADIUS: kernel_radius <= cfg_data[1:0];
          default: ;
        endcase
        input_count  <= '0;
        output_count <= '0;
        out_x        <= '0;
        out_y        <= '0;
        out_base     <= '0;
        in_addr      <= '0;
      end
      if (w_we) wvalid[coef_index[WEIGHT_AW-1:0]] <= 1'b1;
      if (pix_take) begin
        input_count <= in_count_inc;
        in_addr <= (in_addr == STORE_AW'(STORE_DEPTH - 1)) ? '0 : in_addr + 1'b1;
      end
      v1 <= (state == S_TAP);
      v2 <= v1;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (out_load) begin
        out_valid <= 1'b1;
        if (output_count + 24'd1 >= total) begin
          input_count  <= '0;
          output_count <= '0;
          out_x        <= '0;
          out_y        <= '0;
          out_base     <= '0;
          in_addr      <= '0;
        end else begin
          output_count <= output_count + 24'd1;
          if (12'(out_x) == eff_w - 12'd1) begin
            out_x    <= '0;
            out_y    <= out_y + 12'd1;
            out_base <= add_mod(out_base, eff_w);
          end else begin
            out_x <= out_x + 11'd1;
          end
        end
      end
    end
  end

  // datapath: tap walk, multiply stage, accumulate stage, result register
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        kx   <= '0;
        ky   <= '0;
        widx <= '0;
        cur_base <= out_base;
        if (out_y < 12'(kernel_radius)) begin
          back_cnt <= out_y[1:0];
          cur_py   <= '0;
        end else begin
          back_cnt <= kernel_radius;
          cur_py   <= out_y - 12'(kernel_radius);
        end
        for (int c = 0; c < 3; c++) acc[c] <= '0;
      end
      S_BACK: begin
        if (back_cnt != 2'd0) begin
          back_cnt <= back_cnt - 2'd1;
          cur_base <= sub_mod(cur_base, eff_w);
        end
      end
      S_TAP: begin
        widx <= widx + 1'b1;
        if (tap_last_col) begin
          kx <= '0;
          ky <= ky + 3'd1;
          if (next_py != cur_py) begin
            cur_py   <= next_py;
            cur_base <= add_mod(cur_base, eff_w);
          end
        end else begin
          kx <= kx + 3'd1;
        end
      end
      default: ;
    endcase
    wv_q <= wvalid[widx];
    if (v1) begin
      for (int c = 0; c < 3; c++)
        prod[c] <= $signed({1'b0, store_rdata[8*c +: 8]}) *
                   (wv_q ? $signed(w_rdata) : 18'sd0);
    end
    if (v2) begin
      for (int c = 0; c < 3; c++) acc[c] <= acc[c] + 34'(prod[c]);
    end
    if (out_load) begin
      out_blue  <= finish(acc[0]);
      out_green <= finish(acc[1]);
      out_red   <= finish(acc[2]);
      frame_end <= (output_count + 24'd1 >= total);
    end
  end

endmodule

FILE: src/gbr_checker.sv
// Port-level checker for the Gaussian blur core, with its bind statement.
// Depends on gbr_pkg and the top level's ports.
module gbr_checker
  import gbr_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] command,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_blue,
  input logic [7:0] out_green,
  input logic [7:0] out_red,
  input logic       frame_end,
  input logic       cfg_ready
);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_blue) && $stable(out_green) &&
    $stable(out_red) && $stable(frame_end))
    else $error("stalled result changed");

  // a result is only raised while the input side is busy
  a_out_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result raised while input side idle");

  // a weight load does not stall the input
  a_load_fast: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (command == CMD_LOAD) |=> in_ready)
    else $error("weight load stalled the input");

  // an unknown command is dropped at once
  a_none_fast: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (command == CMD_NONE) |=> in_ready)
    else $error("unknown command stalled the input");

  // configuration requests are always taken
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("configuration port not ready");

endmodule

bind gaussian_blur_rgb_clamp_edges_core gbr_checker u_gbr_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .command  (command),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_blue (out_blue),
  .out_green(out_green),
  .out_red  (out_red),
  .frame_end(frame_end),
  .cfg_ready(cfg_ready)
);
